### hdl/windowed_episode_stats_assert.svh
// ----------------------------------------------------------------------------
// windowed_episode_stats assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_EPISODE_STATS_ASSERT_SVH
`define WINDOWED_EPISODE_STATS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define WES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define WES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/wes_pkg.sv
// ----------------------------------------------------------------------------
// wes_pkg
// Shared constants for the windowed episode statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wes_pkg;

  localparam int unsigned WINDOW = 1024;

  localparam int unsigned LEN_W  = 20;
  localparam int unsigned REW_W  = 32;
  localparam int unsigned TOT_W  = 32;
  localparam int unsigned MLEN_W = 28;
  localparam int unsigned FRAC_W = 8;

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned DIV_W  = $clog2(WINDOW + 1);
  localparam int unsigned RSUM_W = REW_W + $clog2(WINDOW);
  localparam int unsigned LSUM_W = LEN_W + $clog2(WINDOW);
  localparam int unsigned QUO_W  = RSUM_W;
  localparam int unsigned CNT_W  = $clog2(QUO_W + 1);
  localparam int unsigned ENT_W  = REW_W + LEN_W;

  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(WINDOW - 1);
  localparam logic [DIV_W-1:0]  WINDOW_DIV = DIV_W'(WINDOW);
  localparam logic [CNT_W-1:0]  LAST_STEP  = CNT_W'(QUO_W - 1);
  localparam logic [TOT_W-1:0]  WINDOW_TOT = TOT_W'(WINDOW);

endpackage

`default_nettype wire

### hdl/windowed_episode_stats.sv
// ----------------------------------------------------------------------------
// windowed_episode_stats
// Sliding-window mean and running peak of episode length and reward.
//
//   channel | direction | handshake              | fields
//   --------+-----------+------------------------+-------------------------------
//   in      | sink      | in_valid_i / in_stall_o | episode_length, episode_reward
//   out     | source    | out_valid_o/out_stall_i | episodes_seen, mean_reward,
//           |           |                        | mean_length, peak_reward,
//           |           |                        | peak_length
//
// One item at a time: the next item is taken only once the result of the last
// one is in the output register. Each item passes ring write-back, sum
// update, divider setup, 42 bit-serial divider steps over the window sum and
// the output register. Reset clears sums, counters and peaks at once; the
// ring needs no clearing. A stalled result waits in the output register; the
// block holds only when a new result finds it unread.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "windowed_episode_stats_assert.svh"

module windowed_episode_stats (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic        [wes_pkg::LEN_W-1:0]      episode_length_i,
  input  wire logic signed [wes_pkg::REW_W-1:0]      episode_reward_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic             [wes_pkg::TOT_W-1:0]      episodes_seen_o,
  output logic signed      [wes_pkg::REW_W-1:0]      mean_reward_o,
  output logic             [wes_pkg::MLEN_W-1:0]     mean_length_o,
  output logic signed      [wes_pkg::REW_W-1:0]      peak_reward_o,
  output logic             [wes_pkg::LEN_W-1:0]      peak_length_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_PREP = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_q, state_d;

  logic in_acc, out_acc, out_free;

  // ring memory, {reward, length} per entry
  logic [wes_pkg::ENT_W-1:0] ring_mem [wes_pkg::WINDOW];
  logic [wes_pkg::ENT_W-1:0] ring_rd_q;

  logic        [wes_pkg::LEN_W-1:0]  len_q, len_d;
  logic signed [wes_pkg::REW_W-1:0]  rew_q, rew_d;
  logic        [wes_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic        [wes_pkg::TOT_W-1:0]  total_q, total_d;
  logic signed [wes_pkg::REW_W:0]    dr_q, dr_d;
  logic signed [wes_pkg::LEN_W:0]    dl_q, dl_d;
  logic signed [wes_pkg::RSUM_W-1:0] sum_r_q, sum_r_d;
  logic        [wes_pkg::LSUM_W-1:0] sum_l_q, sum_l_d;
  logic signed [wes_pkg::REW_W-1:0]  best_r_q, best_r_d;
  logic        [wes_pkg::LEN_W-1:0]  best_l_q, best_l_d;
  logic        [wes_pkg::DIV_W-1:0]  div_q, div_d;
  logic        [wes_pkg::QUO_W-1:0]  num_r_q, num_r_d;
  logic        [wes_pkg::QUO_W-1:0]  num_l_q, num_l_d;
  logic        [wes_pkg::DIV_W-1:0]  rem_r_q, rem_r_d;
  logic        [wes_pkg::DIV_W-1:0]  rem_l_q, rem_l_d;
  logic                              neg_q, neg_d;
  logic        [wes_pkg::CNT_W-1:0]  cnt_q, cnt_d;

  logic                              out_valid_q, out_valid_d;
  logic        [wes_pkg::TOT_W-1:0]  o_seen_q, o_seen_d;
  logic signed [wes_pkg::REW_W-1:0]  o_mrew_q, o_mrew_d;
  logic        [wes_pkg::MLEN_W-1:0] o_mlen_q, o_mlen_d;
  logic signed [wes_pkg::REW_W-1:0]  o_prew_q, o_prew_d;
  logic        [wes_pkg::LEN_W-1:0]  o_plen_q, o_plen_d;

  logic                              full;
  logic signed [wes_pkg::REW_W-1:0]  old_rew;
  logic        [wes_pkg::LEN_W-1:0]  old_len;
  logic        [wes_pkg::DIV_W:0]    rr_sh, rl_sh, rr_sub, rl_sub;
  logic                              rr_ge, rl_ge;
  logic        [wes_pkg::REW_W-1:0]  q_rew;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign full    = (total_q >= wes_pkg::WINDOW_TOT);
  assign old_rew = $signed(ring_rd_q[wes_pkg::ENT_W-1:wes_pkg::LEN_W]);
  assign old_len = ring_rd_q[wes_pkg::LEN_W-1:0];

  // restoring divider steps, one quotient bit per cycle on each channel
  assign rr_sh  = {rem_r_q, num_r_q[wes_pkg::QUO_W-1]};
  assign rl_sh  = {rem_l_q, num_l_q[wes_pkg::QUO_W-1]};
  assign rr_sub = rr_sh - {1'b0, div_q};
  assign rl_sub = rl_sh - {1'b0, div_q};
  assign rr_ge  = (rr_sh >= {1'b0, div_q});
  assign rl_ge  = (rl_sh >= {1'b0, div_q});
  assign q_rew  = num_r_q[wes_pkg::REW_W-1:0];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ring_rd_q <= ring_mem[slot_q];
    end
    if (state_q == ST_UPD) begin
      ring_mem[slot_q] <= {rew_q, len_q};
    end
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    rew_d       = rew_q;
    slot_d      = slot_q;
    total_d     = total_q;
    dr_d        = dr_q;
    dl_d        = dl_q;
    sum_r_d     = sum_r_q;
    sum_l_d     = sum_l_q;
    best_r_d    = best_r_q;
    best_l_d    = best_l_q;
    div_d       = div_q;
    num_r_d     = num_r_q;
    num_l_d     = num_l_q;
    rem_r_d     = rem_r_q;
    rem_l_d     = rem_l_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_acc;
    o_seen_d    = o_seen_q;
    o_mrew_d    = o_mrew_q;
    o_mlen_d    = o_mlen_q;
    o_prew_d    = o_prew_q;
    o_plen_d    = o_plen_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          len_d   = episode_length_i;
          rew_d   = episode_reward_i;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        dr_d = {rew_q[wes_pkg::REW_W-1], rew_q}
             - (full ? {old_rew[wes_pkg::REW_W-1], old_rew} : '0);
        dl_d = {1'b0, len_q} - (full ? {1'b0, old_len} : '0);
        div_d = full ? wes_pkg::WINDOW_DIV : wes_pkg::DIV_W'(total_q + 1'b1);
        if (total_q != '1) begin
          total_d = total_q + 1'b1;
        end
        slot_d = (slot_q == wes_pkg::LAST_SLOT) ? '0 : slot_q + 1'b1;
        if (rew_q > best_r_q) begin
          best_r_d = rew_q;
        end
        if (len_q > best_l_q) begin
          best_l_d = len_q;
        end
        state_d = ST_SUM;
      end
      ST_SUM: begin
        sum_r_d = sum_r_q + wes_pkg::RSUM_W'(dr_q);
        sum_l_d = sum_l_q + wes_pkg::LSUM_W'(dl_q);
        state_d = ST_PREP;
      end
      ST_PREP: begin
        neg_d   = sum_r_q[wes_pkg::RSUM_W-1];
        num_r_d = sum_r_q[wes_pkg::RSUM_W-1] ? wes_pkg::QUO_W'(-sum_r_q)
                                             : wes_pkg::QUO_W'(sum_r_q);
        num_l_d = wes_pkg::QUO_W'({sum_l_q, {wes_pkg::FRAC_W{1'b0}}});
        rem_r_d = '0;
        rem_l_d = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_r_d = rr_ge ? rr_sub[wes_pkg::DIV_W-1:0] : rr_sh[wes_pkg::DIV_W-1:0];
        rem_l_d = rl_ge ? rl_sub[wes_pkg::DIV_W-1:0] : rl_sh[wes_pkg::DIV_W-1:0];
        num_r_d = {num_r_q[wes_pkg::QUO_W-2:0], rr_ge};
        num_l_d = {num_l_q[wes_pkg::QUO_W-2:0], rl_ge};
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == wes_pkg::LAST_STEP) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_seen_d    = total_q;
          o_mrew_d    = neg_q ? $signed(-q_rew) : $signed(q_rew);
          o_mlen_d    = num_l_q[wes_pkg::MLEN_W-1:0];
          o_prew_d    = best_r_q;
          o_plen_d    = best_l_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      total_q     <= '0;
      sum_r_q     <= '0;
      sum_l_q     <= '0;
      best_r_q    <= {1'b1, {(wes_pkg::REW_W-1){1'b0}}};
      best_l_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      total_q     <= total_d;
      sum_r_q     <= sum_r_d;
      sum_l_q     <= sum_l_d;
      best_r_q    <= best_r_d;
      best_l_q    <= best_l_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    rew_q    <= rew_d;
    dr_q     <= dr_d;
    dl_q     <= dl_d;
    div_q    <= div_d;
    num_r_q  <= num_r_d;
    num_l_q  <= num_l_d;
    rem_r_q  <= rem_r_d;
    rem_l_q  <= rem_l_d;
    neg_q    <= neg_d;
    o_seen_q <= o_seen_d;
    o_mrew_q <= o_mrew_d;
    o_mlen_q <= o_mlen_d;
    o_prew_q <= o_prew_d;
    o_plen_q <= o_plen_d;
  end

  assign out_valid_o     = out_valid_q;
  assign episodes_seen_o = o_seen_q;
  assign mean_reward_o   = o_mrew_q;
  assign mean_length_o   = o_mlen_q;
  assign peak_reward_o   = o_prew_q;
  assign peak_length_o   = o_plen_q;

  `WES_ASSERT_NEXT(a_acc_to_upd, in_acc, state_q == ST_UPD, "accepted item did not reach update")
  `WES_ASSERT_NOW(a_div_nonzero, state_q == ST_DIV, div_q != '0, "divisor is zero")
  `WES_ASSERT_NEXT(a_sum_hold, state_q != ST_SUM, $stable(sum_r_q) && $stable(sum_l_q), "window sum moved outside sum step")
  `WES_ASSERT_NOW(a_out_from_div, $rose(out_valid_q), $past(state_q) == ST_OUT, "result raised outside output step")

endmodule

`default_nettype wire
